/* design/ewfe_pkg.sv */
// Shared types and constants for the EMG window feature extractor.
package ewfe_pkg;

    // window length, a power of two
    localparam int unsigned WINDOW_LEN = 64;
    localparam int unsigned WIN_LOG2   = $clog2(WINDOW_LEN);
    localparam int unsigned SAMPLE_W  = 8;
    localparam int unsigned MAX_CH    = 8;
    localparam int unsigned FRAME_W   = SAMPLE_W * MAX_CH;
    localparam int unsigned CH_W      = 3;
    localparam int unsigned MEAN_W    = 14;
    localparam int unsigned SD_W      = 15;
    localparam int unsigned PEAK_W    = 8;
    localparam int unsigned ABS_W     = 8;
    localparam int unsigned SQ_W      = 16;
    localparam int unsigned OUT_DATA_W = 40;
    localparam logic [SD_W-1:0] SD_MAX = '1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STORE,
        ST_ADDR,
        ST_ACC,
        ST_STAT,
        ST_DIV,
        ST_SQRT,
        ST_EMIT
    } t_state;

    function automatic logic [ABS_W-1:0] abs_sample(input logic [SAMPLE_W-1:0] b);
        logic [ABS_W-1:0] r;
        r = b[SAMPLE_W-1] ? ABS_W'(-b) : ABS_W'(b);
        return r;
    endfunction

endpackage

/* design/ewfe_divider.sv */
// Divider by the constant 2**SH - 1, folding the high digits into the low ones.
module ewfe_divider import ewfe_pkg::*; #(
    parameter int unsigned NUM_W = 64,
    parameter int unsigned SH    = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam logic [NUM_W-1:0] MASK = NUM_W'((64'd1 << SH) - 64'd1);

    logic [NUM_W-1:0] r_q;
    logic [NUM_W-1:0] r_r;
    logic             r_busy;
    logic [NUM_W-1:0] w_hi;
    logic [NUM_W-1:0] w_lo;
    logic             w_big;

    assign w_hi   = r_r >> SH;
    assign w_lo   = r_r & MASK;
    assign w_big  = (w_hi != '0);
    assign o_quot = r_q;
    assign o_done = r_busy && !w_big && (w_lo != MASK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_q    <= '0;
            r_r    <= i_num;
        end else if (r_busy && w_big) begin
            // 2^SH*hi + lo = (2^SH-1)*hi + (hi + lo)
            r_q <= r_q + w_hi;
            r_r <= w_hi + w_lo;
        end else if (r_busy && (w_lo == MASK)) begin
            r_q <= r_q + NUM_W'(1);
            r_r <= '0;
        end else begin
            r_busy <= 1'b0;
        end
    end
endmodule

/* design/ewfe_isqrt.sv */
// Bit-pair integer square root, one result bit per cycle.
module ewfe_isqrt import ewfe_pkg::*; #(
    parameter int unsigned IN_W = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [IN_W-1:0]   i_val,
    output logic              o_done,
    output logic [IN_W/2-1:0] o_root
);
    localparam int unsigned RW    = IN_W / 2;
    localparam int unsigned CNT_W = $clog2(RW + 1);

    logic [IN_W-1:0]  r_v;
    logic [RW+1:0]    r_rem;
    logic [RW-1:0]    r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic [RW+1:0]    w_rem;
    logic [RW+1:0]    w_trial;

    assign w_rem   = {r_rem[RW-1:0], r_v[IN_W-1:IN_W-2]};
    assign w_trial = {r_root, 2'b01};
    assign o_root  = r_root;
    assign o_done  = r_busy && (r_cnt == CNT_W'(0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(RW);
            r_v    <= i_val;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy && r_cnt != CNT_W'(0)) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_v   <= {r_v[IN_W-3:0], 2'b00};
            if (w_rem >= w_trial) begin
                r_rem  <= w_rem - w_trial;
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem;
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end else begin
            r_busy <= 1'b0;
        end
    end
endmodule

/* design/emg_window_feature_extractor.sv */
// Top level: window store, sequencer and shared accumulate/divide/root units.
// A frame that does not fill the window is stored through ST_STORE.
// A full window emits CHANNELS results; each channel walks WINDOW_LEN entries,
// then a divide and a square root; output stalls hold the result in ST_EMIT.
// Reset (synchronous, active low) clears fill count, position and sequencer.
module emg_window_feature_extractor import ewfe_pkg::*; #(
    parameter int unsigned CHANNELS   = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // sample_ch0 .. sample_ch7, 8 bits each, ch0 lowest
    input  logic [FRAME_W-1:0]    s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // channel[2:0], mean_abs_q6[16:3], stdev_q8[31:17], peak_abs[39:32]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // last
    output logic                  m_axis_tlast
);
    localparam int unsigned AW    = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int unsigned FW    = $clog2(WINDOW_LEN + 1);
    localparam int unsigned HALF  = WINDOW_LEN / 2;
    localparam int unsigned S_W   = ABS_W + FW;
    localparam int unsigned Q_W   = SQ_W + FW;
    localparam int unsigned NUM_W = 64;

    t_state r_state, n_state;

    logic [FRAME_W-1:0] r_mem [WINDOW_LEN];
    logic [FRAME_W-1:0] r_rd;
    logic [FRAME_W-1:0] r_in;
    logic [FW-1:0]      r_fill;
    logic [AW-1:0]      r_old;
    logic [FW-1:0]      r_idx;
    logic [AW-1:0]      r_addr;
    logic [CH_W-1:0]    r_ch;
    logic [S_W-1:0]     r_s;
    logic [Q_W-1:0]     r_q;
    logic [PEAK_W-1:0]  r_peak;
    logic [MEAN_W-1:0]  r_mean;
    logic [SD_W-1:0]    r_sd;
    logic               r_rdv;
    logic               w_full;
    logic               w_wr;
    logic [AW-1:0]      w_waddr;
    logic [ABS_W-1:0]   w_abs;
    logic               div_start, div_done, sq_start, sq_done;
    logic [NUM_W-1:0]   div_q;
    logic [NUM_W/2-1:0] sq_root;
    logic [2*S_W-1:0]   w_ss;
    logic [Q_W+FW-1:0]  w_nq;
    logic [NUM_W-1:0]   w_num;

    function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
        logic [AW:0] r;
        r = (v >= (AW+1)'(WINDOW_LEN)) ? v - (AW+1)'(WINDOW_LEN) : v;
        return r[AW-1:0];
    endfunction

    assign w_full  = (r_fill >= FW'(WINDOW_LEN));
    assign w_abs   = abs_sample(r_rd[r_ch*SAMPLE_W +: SAMPLE_W]);
    assign w_ss    = r_s * r_s;
    assign w_nq    = (Q_W+FW)'(r_q) * (Q_W+FW)'(WINDOW_LEN);
    // 65536*(N*Q - S*S)/N, exact since N is a power of two
    assign w_num   = NUM_W'(w_nq - (Q_W+FW)'(w_ss)) << (16 - WIN_LOG2);
    assign w_waddr = wrap({1'b0, r_old} + (AW+1)'(r_fill));

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_EMIT);
    assign m_axis_tdata  = {r_peak, r_sd, r_mean, r_ch};
    assign m_axis_tlast  = (r_ch == CH_W'(CHANNELS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (s_axis_tvalid) n_state = w_full ? ST_ADDR : ST_STORE;
            ST_STORE: n_state = ST_IDLE;
            ST_ADDR:  n_state = ST_ACC;
            ST_ACC:   if (r_rdv && r_idx == FW'(WINDOW_LEN - 1)) n_state = ST_STAT;
            ST_STAT:  n_state = ST_DIV;
            ST_DIV:   if (div_done) n_state = ST_SQRT;
            ST_SQRT:  if (sq_done) n_state = ST_EMIT;
            ST_EMIT: begin
                if (m_axis_tready) begin
                    n_state = (r_ch == CH_W'(CHANNELS - 1)) ? ST_STORE : ST_ADDR;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        div_start = (r_state == ST_STAT);
        sq_start  = (r_state == ST_DIV) && div_done;
        w_wr      = (r_state == ST_STORE);
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[w_waddr] <= r_in;
        r_rd <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_old   <= '0;
            r_ch    <= '0;
            r_rdv   <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_in <= s_axis_tdata;
                        r_ch <= '0;
                    end
                end
                ST_STORE: r_fill <= r_fill + FW'(1);
                ST_ADDR: begin
                    r_addr <= r_old;
                    r_idx  <= '0;
                    r_rdv  <= 1'b0;
                    r_s    <= '0;
                    r_q    <= '0;
                    r_peak <= '0;
                end
                ST_ACC: begin
                    r_rdv  <= 1'b1;
                    r_addr <= wrap({1'b0, r_addr} + (AW+1)'(1));
                    if (r_rdv) begin
                        r_idx  <= r_idx + FW'(1);
                        r_s    <= r_s + S_W'(w_abs);
                        r_q    <= r_q + Q_W'(w_abs) * Q_W'(w_abs);
                        if (w_abs > r_peak) r_peak <= w_abs;
                    end
                end
                ST_STAT: begin
                    r_mean <= MEAN_W'({r_s, 6'b0} >> WIN_LOG2);
                end
                ST_SQRT: begin
                    if (sq_done) begin
                        r_sd <= (sq_root > (NUM_W/2)'(SD_MAX)) ? SD_MAX : SD_W'(sq_root);
                    end
                end
                ST_EMIT: begin
                    if (m_axis_tready) begin
                        if (r_ch == CH_W'(CHANNELS - 1)) begin
                            r_old  <= wrap({1'b0, r_old} + (AW+1)'(HALF));
                            r_fill <= FW'(WINDOW_LEN - HALF);
                        end else begin
                            r_ch <= r_ch + CH_W'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    ewfe_divider #(.NUM_W(NUM_W), .SH(WIN_LOG2)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (w_num),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    ewfe_isqrt #(.IN_W(NUM_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_val   (div_q),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );
endmodule
